FILE: rtl/core/lei_pkg.sv
package lei_pkg;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NULL     = 3'd1,
    ST_EOF      = 3'd2,
    ST_NODATA   = 3'd3,
    ST_OVERFLOW = 3'd4
  } status_t;

  localparam logic [7:0] PFX_NULL = 8'hFB;
  localparam logic [7:0] PFX_LEN2 = 8'hFC;
  localparam logic [7:0] PFX_LEN3 = 8'hFD;
  localparam logic [7:0] PFX_LEN8 = 8'hFE;
  localparam logic [7:0] PFX_EOF  = 8'hFF;

  localparam logic [3:0] LEN2 = 4'd2;
  localparam logic [3:0] LEN3 = 4'd3;
  localparam logic [3:0] LEN8 = 4'd8;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       buffer_end;
  } in_item_t;

  typedef struct packed {
    logic [63:0] value;
    status_t     status;
  } result_t;

  typedef struct packed {
    logic    emit;
    result_t res;
  } core_out_t;

endpackage

FILE: rtl/core/lei_in_stage.sv
module lei_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        data_byte,
  input  logic              buffer_end,
  input  logic              go,
  output logic              s1_valid,
  output lei_pkg::in_item_t s1_item
);
  import lei_pkg::*;

  logic accept;

  assign in_stall = s1_valid && !go;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item.data_byte  <= data_byte;
      s1_item.buffer_end <= buffer_end;
    end
  end

endmodule

FILE: rtl/core/lei_core.sv
module lei_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               go,
  input  lei_pkg::in_item_t  item,
  input  logic               wide_mode,
  output lei_pkg::core_out_t cout
);
  import lei_pkg::*;

  logic [3:0]  bytes_needed;
  logic [3:0]  bytes_taken;
  logic [63:0] accumulator;
  logic [3:0]  bytes_needed_next;
  logic [3:0]  bytes_taken_next;
  logic [63:0] accumulator_next;
  logic [63:0] acc_merged;
  logic [3:0]  taken_inc;

  always_comb begin
    acc_merged = accumulator;
    for (int i = 0; i < 8; i++) begin
      if (bytes_taken[2:0] == 3'(i)) begin
        acc_merged[i*8 +: 8] = accumulator[i*8 +: 8] | item.data_byte;
      end
    end
  end

  assign taken_inc = bytes_taken + 4'd1;

  always_comb begin
    bytes_needed_next = bytes_needed;
    bytes_taken_next  = bytes_taken;
    accumulator_next  = accumulator;
    cout.emit         = 1'b0;
    cout.res.value    = '0;
    cout.res.status   = ST_OK;
    if (bytes_needed == 4'd0) begin
      priority if (item.data_byte < PFX_NULL) begin
        cout.emit      = 1'b1;
        cout.res.value = {56'd0, item.data_byte};
      end else if (item.data_byte == PFX_NULL) begin
        cout.emit       = 1'b1;
        cout.res.status = ST_NULL;
      end else if (item.data_byte == PFX_EOF) begin
        cout.emit       = 1'b1;
        cout.res.status = ST_EOF;
      end else begin
        priority if (item.data_byte == PFX_LEN2) begin
          bytes_needed_next = LEN2;
        end else if (item.data_byte == PFX_LEN3) begin
          bytes_needed_next = LEN3;
        end else begin
          bytes_needed_next = LEN8;
        end
        bytes_taken_next = 4'd0;
        accumulator_next = '0;
        if (item.buffer_end) begin
          bytes_needed_next = 4'd0;
          cout.emit         = 1'b1;
          cout.res.status   = ST_NODATA;
        end
      end
    end else begin
      accumulator_next = acc_merged;
      bytes_taken_next = taken_inc;
      if (taken_inc >= bytes_needed) begin
        bytes_needed_next = 4'd0;
        bytes_taken_next  = 4'd0;
        accumulator_next  = '0;
        cout.emit         = 1'b1;
        if (wide_mode) begin
          cout.res.value = acc_merged;
        end else begin
          cout.res.value = {32'd0, acc_merged[31:0]};
          if (acc_merged[63:32] != 32'd0) begin
            cout.res.status = ST_OVERFLOW;
          end
        end
      end else if (item.buffer_end) begin
        bytes_needed_next = 4'd0;
        bytes_taken_next  = 4'd0;
        accumulator_next  = '0;
        cout.emit         = 1'b1;
        cout.res.status   = ST_NODATA;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_needed <= '0;
      bytes_taken  <= '0;
      accumulator  <= '0;
    end else if (go) begin
      bytes_needed <= bytes_needed_next;
      bytes_taken  <= bytes_taken_next;
      accumulator  <= accumulator_next;
    end
  end

endmodule

FILE: rtl/core/lei_out_stage.sv
module lei_out_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               s1_valid,
  input  lei_pkg::core_out_t cout,
  output logic               go,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [63:0]        value,
  output logic [2:0]         status
);
  import lei_pkg::*;

  logic    load;
  result_t res;

  assign go     = s1_valid && (!out_valid || !out_stall);
  assign load   = go && cout.emit;
  assign value  = res.value;
  assign status = res.status;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= cout.res;
    end
  end

endmodule

FILE: rtl/core/length_encoded_int_decoder.sv
// A result passes the input register (which holds its byte) and then the result register before it is valid.
// Throughput: one byte per cycle; while a result waits on stall one more byte is taken,
// then the input stalls until the result is accepted.
// Bytes that complete no field give no result; they are still consumed from the input register.
// Reset (rst, synchronous, active high): decoder idle, both stages empty, wide_mode = 1.
module length_encoded_int_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        buffer_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] value,
  output logic [2:0]  status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_wide_mode
);
  import lei_pkg::*;

  logic      wide_mode;
  logic      go;
  logic      s1_valid;
  in_item_t  s1_item;
  core_out_t cout;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wide_mode <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      wide_mode <= cfg_wide_mode;
    end
  end

  lei_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .buffer_end (buffer_end),
    .go         (go),
    .s1_valid   (s1_valid),
    .s1_item    (s1_item)
  );

  lei_core u_core (
    .clk       (clk),
    .rst       (rst),
    .go        (go),
    .item      (s1_item),
    .wide_mode (wide_mode),
    .cout      (cout)
  );

  lei_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .s1_valid  (s1_valid),
    .cout      (cout),
    .go        (go),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .value     (value),
    .status    (status)
  );

endmodule

FILE: rtl/core/lei_checker.sv
module lei_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] value,
  input logic [2:0]  status
);
  import lei_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(value) && $stable(status))
    else $error("result changed while stalled");

  a_zero_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_NULL || status == ST_EOF || status == ST_NODATA)
      |-> value == 64'd0)
    else $error("nonzero value with null, eof or no-data status");

  a_overflow_low: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_OVERFLOW |-> value[63:32] == 32'd0)
    else $error("overflow result not truncated to 32 bits");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a blocked result");

endmodule

bind length_encoded_int_decoder lei_checker u_lei_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .value     (value),
  .status    (status)
);
